@@ rtl/core/direct_mapped_cache_tag_lookup_defines.svh @@
// ----------------------------------------------------------------------------
// Direct-mapped cache tag lookup: assertion macros
// Shared concurrent assertion forms, clocked and disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef DIRECT_MAPPED_CACHE_TAG_LOOKUP_DEFINES_SVH
`define DIRECT_MAPPED_CACHE_TAG_LOOKUP_DEFINES_SVH

// same-cycle implication
`define DMCTL_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dmctl assertion failed");

// next-cycle implication
`define DMCTL_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dmctl assertion failed");

`endif

@@ rtl/core/dmctl_pkg.sv @@
// ----------------------------------------------------------------------------
// dmctl_pkg
// Constants and register codes of the direct-mapped cache tag lookup.
// ----------------------------------------------------------------------------
package dmctl_pkg;

  localparam int ADDR_W      = 32;
  localparam int LINE_IDX_W  = 8;
  localparam int CNT_W       = 32;
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 8;
  localparam int OUT_DATA_W  = 144;

  localparam int OFFSET_REG_W = 5;
  localparam int INDEX_REG_W  = 4;

  localparam logic [OFFSET_REG_W-1:0] OFFSET_MAX   = 5'd16;
  localparam logic [INDEX_REG_W-1:0]  INDEX_MAX    = 4'd8;
  localparam logic [OFFSET_REG_W-1:0] OFFSET_RESET = 5'd2;
  localparam logic [INDEX_REG_W-1:0]  INDEX_RESET  = 4'd8;

  localparam logic [CFG_INDEX_W-1:0] REG_OFFSET_WIDTH = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_INDEX_WIDTH  = 8'd1;

endpackage

@@ rtl/core/dmctl_ram.sv @@
// ----------------------------------------------------------------------------
// dmctl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dmctl_ram #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 256
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/core/direct_mapped_cache_tag_lookup.sv @@
// ----------------------------------------------------------------------------
// direct_mapped_cache_tag_lookup
// Direct-mapped tag store with hit, miss and eviction totals.
// ----------------------------------------------------------------------------
// Takes one address per cycle while the output side does not stall and no
// clearing pass runs, and returns one result per address through the lookup
// and output registers. The tag store is a single RAM (tag plus valid bit
// per line) with one read and one write port; each address reads its line
// on transfer and writes it back as it leaves the lookup stage, with the last
// write forwarded to the next lookup. After reset a clearing pass invalidates
// every line, keeping in_tready low while configuration writes are taken.
module direct_mapped_cache_tag_lookup #(
  parameter int LINE_COUNT    = 256,
  parameter int ADDRESS_WIDTH = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // configuration write channel
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [dmctl_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [dmctl_pkg::CFG_DATA_W-1:0]   cfg_data,
  // input stream
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [dmctl_pkg::ADDR_W-1:0]       in_tdata,   // address[31:0]
  // result stream
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // is_hit[0], is_eviction[1], line_index[9:2], line_tag[41:10],
  // hit_total[73:42], miss_total[105:74], eviction_total[137:106], zero pad
  output logic [dmctl_pkg::OUT_DATA_W-1:0]   out_tdata
);

  import dmctl_pkg::*;

  localparam int IDX_W = (LINE_COUNT > 1) ? $clog2(LINE_COUNT) : 1;
  localparam int TAG_W = ADDRESS_WIDTH;
  localparam int ENT_W = TAG_W + 1;

  typedef enum logic [1:0] {
    ST_CLEAR = 2'b01,
    ST_RUN   = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic [IDX_W-1:0] clr_cnt_r, clr_cnt_nxt;

  logic [OFFSET_REG_W-1:0] offset_width_r;
  logic [INDEX_REG_W-1:0]  index_width_r;

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_width_r <= OFFSET_RESET;
      index_width_r  <= INDEX_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_OFFSET_WIDTH) begin
        offset_width_r <= cfg_data[OFFSET_REG_W-1:0];
      end else if (cfg_index == REG_INDEX_WIDTH) begin
        index_width_r <= cfg_data[INDEX_REG_W-1:0];
      end
    end
  end

  // address split
  logic [OFFSET_REG_W-1:0] ow;
  logic [INDEX_REG_W-1:0]  iw;
  logic [TAG_W-1:0]        addr_w;
  logic [TAG_W-1:0]        block;
  logic [LINE_IDX_W-1:0]   iw_mask;
  logic [LINE_IDX_W-1:0]   line_raw;
  logic [LINE_IDX_W-1:0]   line_in;
  logic [TAG_W-1:0]        tag_in;
  logic [LINE_IDX_W-1:0]   line_mod [256];

  for (genvar g = 0; g < 256; g++) begin : g_mod
    assign line_mod[g] = LINE_IDX_W'(g % LINE_COUNT);
  end

  always_comb begin
    ow       = (offset_width_r > OFFSET_MAX) ? OFFSET_MAX : offset_width_r;
    iw       = (index_width_r > INDEX_MAX) ? INDEX_MAX : index_width_r;
    addr_w   = in_tdata[TAG_W-1:0];
    block    = addr_w >> ow;
    iw_mask  = LINE_IDX_W'((9'd1 << iw) - 9'd1);
    line_raw = block[LINE_IDX_W-1:0] & iw_mask;
    line_in  = line_mod[line_raw];
    tag_in   = block >> iw;
  end

  // lookup stage
  logic                  s1_vld_r;
  logic [LINE_IDX_W-1:0] s1_line_r;
  logic [TAG_W-1:0]      s1_tag_r;
  logic                  s1_fire;
  logic                  in_xfer;

  logic                  fwd_vld_r;
  logic [LINE_IDX_W-1:0] fwd_line_r;
  logic [TAG_W-1:0]      fwd_tag_r;

  logic                  out_vld_r;
  logic                  out_hit_r;
  logic                  out_evict_r;
  logic [LINE_IDX_W-1:0] out_line_r;
  logic [TAG_W-1:0]      out_tag_r;

  logic [CNT_W-1:0] hit_cnt_r, hit_cnt_nxt;
  logic [CNT_W-1:0] miss_cnt_r, miss_cnt_nxt;
  logic [CNT_W-1:0] evict_cnt_r, evict_cnt_nxt;

  assign s1_fire   = s1_vld_r && (!out_vld_r || out_tready);
  assign in_tready = (state_r == ST_RUN) && (!s1_vld_r || s1_fire);
  assign in_xfer   = in_tvalid && in_tready;

  // tag RAM
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [ENT_W-1:0] ram_wdata;
  logic [ENT_W-1:0] ram_rdata;

  always_comb begin
    if (state_r == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt_r;
      ram_wdata = '0;
    end else begin
      ram_we    = s1_fire;
      ram_waddr = IDX_W'(s1_line_r);
      ram_wdata = {1'b1, s1_tag_r};
    end
  end

  dmctl_ram #(
    .WIDTH(ENT_W),
    .DEPTH(LINE_COUNT)
  ) u_tag_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (in_xfer),
    .raddr(IDX_W'(line_in)),
    .rdata(ram_rdata)
  );

  // clearing pass
  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    case (state_r)
      ST_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + IDX_W'(1);
        if (clr_cnt_r == IDX_W'(LINE_COUNT - 1)) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        state_nxt = ST_RUN;
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  // compare and count
  logic             ent_valid;
  logic [TAG_W-1:0] ent_tag;
  logic             hit;
  logic             evict;

  always_comb begin
    if (fwd_vld_r && (fwd_line_r == s1_line_r)) begin
      ent_valid = 1'b1;
      ent_tag   = fwd_tag_r;
    end else begin
      ent_valid = ram_rdata[TAG_W];
      ent_tag   = ram_rdata[TAG_W-1:0];
    end
    hit           = ent_valid && (ent_tag == s1_tag_r);
    evict         = ent_valid && (ent_tag != s1_tag_r);
    hit_cnt_nxt   = hit_cnt_r + CNT_W'(hit);
    miss_cnt_nxt  = miss_cnt_r + CNT_W'(!hit);
    evict_cnt_nxt = evict_cnt_r + CNT_W'(evict);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r    <= 1'b0;
      fwd_vld_r   <= 1'b0;
      out_vld_r   <= 1'b0;
      hit_cnt_r   <= '0;
      miss_cnt_r  <= '0;
      evict_cnt_r <= '0;
    end else begin
      if (in_xfer) begin
        s1_vld_r <= 1'b1;
      end else if (s1_fire) begin
        s1_vld_r <= 1'b0;
      end
      if (s1_fire) begin
        fwd_vld_r   <= 1'b1;
        out_vld_r   <= 1'b1;
        hit_cnt_r   <= hit_cnt_nxt;
        miss_cnt_r  <= miss_cnt_nxt;
        evict_cnt_r <= evict_cnt_nxt;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_line_r <= line_in;
      s1_tag_r  <= tag_in;
    end
    if (s1_fire) begin
      fwd_line_r  <= s1_line_r;
      fwd_tag_r   <= s1_tag_r;
      out_hit_r   <= hit;
      out_evict_r <= evict;
      out_line_r  <= s1_line_r;
      out_tag_r   <= s1_tag_r;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {6'd0, evict_cnt_r, miss_cnt_r, hit_cnt_r,
                       ADDR_W'(out_tag_r), out_line_r, out_evict_r, out_hit_r};

  `include "direct_mapped_cache_tag_lookup_defines.svh"

  `DMCTL_ASSERT_IMP(a_no_input_in_clear, clk, rst_n, state_r == ST_CLEAR, !in_tready)
  `DMCTL_ASSERT_IMP(a_hit_excl_evict, clk, rst_n, out_vld_r, !(out_hit_r && out_evict_r))
  `DMCTL_ASSERT_NXT(a_lookup_to_out, clk, rst_n, s1_fire, out_vld_r)
  `DMCTL_ASSERT_NXT(a_one_count_step, clk, rst_n, s1_fire,
                    CNT_W'(hit_cnt_r + miss_cnt_r) == CNT_W'($past(hit_cnt_r + miss_cnt_r) + CNT_W'(1)))

endmodule
